/* sv/mfd_pkg.sv */
// shared constants, action codes and controller/datapath interface types
`default_nettype none
package mfd_pkg;

  localparam int COLUMNS     = 128;
  localparam int PAGES       = 8;
  localparam int ROWS        = PAGES * 8;
  localparam int STORE_BYTES = COLUMNS * PAGES;
  localparam int ADDR_W      = $clog2(STORE_BYTES);

  typedef enum logic [2:0] {
    ACT_PLOT     = 3'd0,
    ACT_RECT     = 3'd1,
    ACT_FILL     = 3'd2,
    ACT_FILL_ALL = 3'd3,
    ACT_READ     = 3'd4
  } action_t;

  typedef struct packed {
    logic load;
    logic rd_pix;
    logic wr_pix;
    logic rd_byte;
    logic sweep_wr;
    logic sweep_zero;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    action_t act_new;
    logic    start_empty;
    logic    walk_last;
    logic    sweep_last;
  } dp_sts_t;

endpackage
`default_nettype wire

/* sv/mfd_datapath.sv */
// frame store, pixel walk counters, read-modify-write path and result register
`default_nettype none
module mfd_datapath (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [2:0]      in_action,
  input  logic [7:0]      in_x_start,
  input  logic [6:0]      in_y_start,
  input  logic [7:0]      in_x_end,
  input  logic [6:0]      in_y_end,
  input  logic            in_pixel_on,
  input  logic            in_low_bit_first,
  input  logic [7:0]      in_fill_value,
  input  logic [6:0]      in_read_column,
  input  logic [2:0]      in_read_page,
  input  mfd_pkg::dp_cmd_t cmd,
  output mfd_pkg::dp_sts_t sts,
  output logic [7:0]      out_read_data
);
  import mfd_pkg::*;

  logic [7:0]        mem_r [STORE_BYTES];
  logic [7:0]        rdata_r;

  action_t           act_r;
  logic [7:0]        xs_r, xe_r;
  logic [6:0]        ys_r, ye_r;
  logic              on_r, lsb_r;
  logic [7:0]        fill_r;
  logic [ADDR_W-1:0] byte_addr_r;
  logic              read_ok_r;

  logic [7:0]        i_r, i_nxt;
  logic [6:0]        j_r, j_nxt;
  logic              sub_r, sub_nxt;
  logic              vert_r, vert_nxt;
  logic [ADDR_W-1:0] sweep_r, sweep_nxt;
  logic [7:0]        out_data_r;

  logic [7:0]        px, px_fix;
  logic [6:0]        py, py_fix;
  logic              lsb_sel, off_panel;
  logic [2:0]        off;
  logic [7:0]        mask, modified;
  logic [ADDR_W-1:0] pix_addr;
  logic              v_nonempty, walk_last;
  logic              re, we;
  logic [ADDR_W-1:0] raddr, waddr;
  logic [7:0]        wdata;

  // start-of-walk decode straight from the incoming beat
  always_comb begin
    sts.act_new     = action_t'(in_action);
    sts.start_empty = 1'b0;
    sts.walk_last   = walk_last;
    sts.sweep_last  = (32'(sweep_r) == STORE_BYTES - 1);
    case (action_t'(in_action))
      ACT_RECT: sts.start_empty = (in_x_start > in_x_end) && (in_y_start > in_y_end);
      ACT_FILL: sts.start_empty = (in_x_start >= in_x_end) || (in_y_start >= in_y_end);
      default:  sts.start_empty = 1'b0;
    endcase
  end

  // current pixel
  always_comb begin
    px      = xs_r;
    py      = ys_r;
    lsb_sel = lsb_r;
    case (act_r)
      ACT_RECT: begin
        lsb_sel = 1'b1;
        if (!vert_r) begin
          px = i_r;
          py = sub_r ? ye_r : ys_r;
        end else begin
          px = sub_r ? xe_r : xs_r;
          py = i_r[6:0];
        end
      end
      ACT_FILL: begin
        lsb_sel = 1'b0;
        px      = i_r;
        py      = j_r;
      end
      default: begin
        px      = xs_r;
        py      = ys_r;
        lsb_sel = lsb_r;
      end
    endcase
  end

  // off-panel pixels land on (0,0)
  assign off_panel = (32'(px) > COLUMNS - 1) || (32'(py) > ROWS - 1);
  assign px_fix    = off_panel ? 8'd0 : px;
  assign py_fix    = off_panel ? 7'd0 : py;
  assign off       = py_fix[2:0];
  assign mask      = lsb_sel ? (8'h01 << off) : (8'h80 >> off);
  assign pix_addr  = ADDR_W'(32'(py_fix[6:3]) * COLUMNS + 32'(px_fix));
  assign modified  = on_r ? (rdata_r | mask) : (rdata_r & ~mask);

  assign v_nonempty = (ys_r <= ye_r);

  always_comb begin
    case (act_r)
      ACT_RECT: walk_last = sub_r && ((!vert_r && (i_r == xe_r) && !v_nonempty) ||
                                      (vert_r && (i_r == {1'b0, ye_r})));
      ACT_FILL: walk_last = (i_r == xe_r - 8'd1) && (j_r == ye_r - 7'd1);
      default:  walk_last = 1'b1;
    endcase
  end

  // walk counters
  always_comb begin
    i_nxt    = i_r;
    j_nxt    = j_r;
    sub_nxt  = sub_r;
    vert_nxt = vert_r;
    if (cmd.load) begin
      sub_nxt  = 1'b0;
      j_nxt    = in_y_start;
      vert_nxt = (action_t'(in_action) == ACT_RECT) && (in_x_start > in_x_end);
      i_nxt    = vert_nxt ? {1'b0, in_y_start} : in_x_start;
    end else if (cmd.wr_pix && !walk_last) begin
      case (act_r)
        ACT_RECT: begin
          if (!sub_r) begin
            sub_nxt = 1'b1;
          end else begin
            sub_nxt = 1'b0;
            if (!vert_r && (i_r == xe_r)) begin
              vert_nxt = 1'b1;
              i_nxt    = {1'b0, ys_r};
            end else begin
              i_nxt = i_r + 8'd1;
            end
          end
        end
        ACT_FILL: begin
          if (j_r == ye_r - 7'd1) begin
            j_nxt = ys_r;
            i_nxt = i_r + 8'd1;
          end else begin
            j_nxt = j_r + 7'd1;
          end
        end
        default: begin
          i_nxt = i_r;
        end
      endcase
    end
  end

  always_comb begin
    sweep_nxt = sweep_r;
    if (cmd.sweep_wr) begin
      sweep_nxt = sts.sweep_last ? '0 : sweep_r + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r <= '0;
    end else begin
      sweep_r <= sweep_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    sub_r  <= sub_nxt;
    vert_r <= vert_nxt;
    if (cmd.load) begin
      act_r       <= action_t'(in_action);
      xs_r        <= in_x_start;
      ys_r        <= in_y_start;
      xe_r        <= in_x_end;
      ye_r        <= in_y_end;
      on_r        <= in_pixel_on;
      lsb_r       <= in_low_bit_first;
      fill_r      <= in_fill_value;
      byte_addr_r <= ADDR_W'(32'(in_read_page) * COLUMNS + 32'(in_read_column));
      read_ok_r   <= (32'(in_read_column) < COLUMNS) && (32'(in_read_page) < PAGES);
    end
    if (cmd.load_out) begin
      out_data_r <= ((act_r == ACT_READ) && read_ok_r) ? rdata_r : 8'd0;
    end
  end

  // frame store: one write port, one registered read port
  assign re    = cmd.rd_pix | cmd.rd_byte;
  assign raddr = cmd.rd_byte ? byte_addr_r : pix_addr;
  assign we    = cmd.wr_pix | cmd.sweep_wr;
  assign waddr = cmd.sweep_wr ? sweep_r : pix_addr;
  assign wdata = cmd.sweep_wr ? (cmd.sweep_zero ? 8'd0 : fill_r) : modified;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign out_read_data = out_data_r;

  a_sweep_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sweep_wr && sts.sweep_last |=> sweep_r == '0)
    else $error("sweep counter did not wrap");

  a_no_rw_collide: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.wr_pix && cmd.sweep_wr))
    else $error("pixel write during sweep");

  a_single_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(re && we))
    else $error("read and write of the frame store in one cycle");

endmodule
`default_nettype wire

/* sv/mfd_ctrl.sv */
// controller state machine: clear pass, pixel read-modify-write, sweeps, result handoff
`default_nettype none
module mfd_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  mfd_pkg::dp_sts_t sts,
  output mfd_pkg::dp_cmd_t cmd
);
  import mfd_pkg::*;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_PRD   = 7'b0000100,
    S_PWR   = 7'b0001000,
    S_FILL  = 7'b0010000,
    S_RBYTE = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept, slot_free;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    cmd.load       = accept;
    case (state_r)
      S_CLEAR: begin
        cmd.sweep_wr   = 1'b1;
        cmd.sweep_zero = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          case (sts.act_new)
            ACT_PLOT:     state_nxt = S_PRD;
            ACT_RECT,
            ACT_FILL:     state_nxt = sts.start_empty ? S_DONE : S_PRD;
            ACT_FILL_ALL: state_nxt = S_FILL;
            ACT_READ:     state_nxt = S_RBYTE;
            default:      state_nxt = S_DONE;
          endcase
        end
      end
      S_PRD: begin
        cmd.rd_pix = 1'b1;
        state_nxt  = S_PWR;
      end
      S_PWR: begin
        cmd.wr_pix = 1'b1;
        state_nxt  = sts.walk_last ? S_DONE : S_PRD;
      end
      S_FILL: begin
        cmd.sweep_wr = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = S_DONE;
        end
      end
      S_RBYTE: begin
        cmd.rd_byte = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (slot_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  assign out_valid_nxt = cmd.load_out ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_write_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PWR |-> $past(state_r) == S_PRD)
    else $error("pixel write without preceding read");

  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLEAR |-> in_stall && !out_valid_r)
    else $error("activity during clear pass");

  a_result_posted: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid_r && state_r == S_IDLE)
    else $error("result not posted");

endmodule
`default_nettype wire

/* sv/mono_page_framebuffer_draw_unit.sv */
// top level of the monochrome page frame store draw unit
// from accept to result: plot, and each pixel of a rectangle or fill area, is a read then
// a write of its column byte; read fetches one byte, fill all sweeps every byte, and an
// empty shape or an unused code goes straight to the result
// throughput: a new beat is taken only once the result of the last one is posted
// after reset a clearing pass writes zero to all 1024 bytes, in_stall high during the pass
`default_nettype none
module mono_page_framebuffer_draw_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_action,
  input  logic [7:0] in_x_start,
  input  logic [6:0] in_y_start,
  input  logic [7:0] in_x_end,
  input  logic [6:0] in_y_end,
  input  logic       in_pixel_on,
  input  logic       in_low_bit_first,
  input  logic [7:0] in_fill_value,
  input  logic [6:0] in_read_column,
  input  logic [2:0] in_read_page,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_read_data
);
  import mfd_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  mfd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  mfd_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_action        (in_action),
    .in_x_start       (in_x_start),
    .in_y_start       (in_y_start),
    .in_x_end         (in_x_end),
    .in_y_end         (in_y_end),
    .in_pixel_on      (in_pixel_on),
    .in_low_bit_first (in_low_bit_first),
    .in_fill_value    (in_fill_value),
    .in_read_column   (in_read_column),
    .in_read_page     (in_read_page),
    .cmd              (cmd),
    .sts              (sts),
    .out_read_data    (out_read_data)
  );

endmodule
`default_nettype wire

/* verif/mfd_draw_checker.sv */
// checker for the draw unit: shadow frame store, read-back prediction and result compare
`timescale 1ns / 100ps
module mfd_draw_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [2:0] in_action,
  input  logic [7:0] in_x_start,
  input  logic [6:0] in_y_start,
  input  logic [7:0] in_x_end,
  input  logic [6:0] in_y_end,
  input  logic       in_pixel_on,
  input  logic       in_low_bit_first,
  input  logic [7:0] in_fill_value,
  input  logic [6:0] in_read_column,
  input  logic [2:0] in_read_page,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_read_data,
  output int         fail_count,
  output int         outstanding,
  output int         results_seen
);
  import mfd_pkg::*;

  logic [7:0] shadow_store [STORE_BYTES];
  logic [7:0] read_back_q [$];

  function automatic void mark_pixel(input int x, input int y, input logic on,
                                     input logic lsb);
    int px;
    int py;
    int addr;
    logic [7:0] mask;
    px = x;
    py = y;
    // off-panel pixels land on the top-left pixel
    if (px > COLUMNS - 1 || py > ROWS - 1) begin
      px = 0;
      py = 0;
    end
    mask = lsb ? (8'h01 << (py % 8)) : (8'h80 >> (py % 8));
    addr = (py / 8) * COLUMNS + px;
    if (addr < STORE_BYTES) begin
      if (on) shadow_store[addr] = shadow_store[addr] | mask;
      else shadow_store[addr] = shadow_store[addr] & ~mask;
    end
  endfunction

  function automatic logic [7:0] predict_read_data(
    input logic [2:0] act, input int xs, input int ys, input int xe, input int ye,
    input logic on, input logic lsb, input logic [7:0] fill, input int col,
    input int page);
    int i;
    int j;
    logic [7:0] data;
    data = '0;
    case (act)
      ACT_PLOT: mark_pixel(xs, ys, on, lsb);
      ACT_RECT: begin
        for (i = xs; i <= xe; i++) begin
          mark_pixel(i, ys, on, 1'b1);
          mark_pixel(i, ye, on, 1'b1);
        end
        for (i = ys; i <= ye; i++) begin
          mark_pixel(xs, i, on, 1'b1);
          mark_pixel(xe, i, on, 1'b1);
        end
      end
      ACT_FILL: begin
        for (i = xs; i < xe; i++)
          for (j = ys; j < ye; j++)
            mark_pixel(i, j, on, 1'b0);
      end
      ACT_FILL_ALL: begin
        for (i = 0; i < STORE_BYTES; i++) shadow_store[i] = fill;
      end
      ACT_READ: begin
        if (col < COLUMNS && page < PAGES) data = shadow_store[page * COLUMNS + col];
      end
      default: ;
    endcase
    return data;
  endfunction

  always @(posedge clk) begin : watch
    logic [7:0] want;
    if (!rst_n) begin
      for (int k = 0; k < STORE_BYTES; k++) shadow_store[k] = '0;
      read_back_q.delete();
      outstanding <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        if (read_back_q.size() == 0) begin
          fail_count <= fail_count + 1;
          $error("read_data beat with nothing expected: expected none, actual 8'h%02h",
                 out_read_data);
        end else begin
          want = read_back_q.pop_front();
          if (want !== out_read_data) begin
            fail_count <= fail_count + 1;
            $error("read_data mismatch: expected 8'h%02h, actual 8'h%02h",
                   want, out_read_data);
          end
        end
      end
      if (in_valid && !in_stall)
        read_back_q.push_back(predict_read_data(in_action, in_x_start, in_y_start,
          in_x_end, in_y_end, in_pixel_on, in_low_bit_first, in_fill_value,
          in_read_column, in_read_page));
      outstanding <= read_back_q.size();
    end
  end

endmodule

/* verif/tb_mono_page_framebuffer_draw_unit.sv */
// testbench top for the draw unit: stimulus, receiver stalls, watchdog and verdict
`timescale 1ns / 100ps
module tb_mono_page_framebuffer_draw_unit;
  import mfd_pkg::*;

  localparam logic [2:0] ACT_SPARE_FIRST = ACT_READ + 3'd1;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 200000;
  localparam int RESET_CYCLES   = 12;
  localparam int TAIL_CYCLES    = 40;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] x_start;
    logic [6:0] y_start;
    logic [7:0] x_end;
    logic [6:0] y_end;
    logic       pixel_on;
    logic       low_bit_first;
    logic [7:0] fill_value;
    logic [6:0] read_column;
    logic [2:0] read_page;
  } draw_beat_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [2:0] in_action = '0;
  logic [7:0] in_x_start = '0;
  logic [6:0] in_y_start = '0;
  logic [7:0] in_x_end = '0;
  logic [6:0] in_y_end = '0;
  logic       in_pixel_on = 1'b0;
  logic       in_low_bit_first = 1'b0;
  logic [7:0] in_fill_value = '0;
  logic [6:0] in_read_column = '0;
  logic [2:0] in_read_page = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_read_data;

  int fail_count;
  int outstanding;
  int results_seen;
  int tx_idle_pct = 20;
  int rx_idle_pct = 84;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int idle_cycles = 0;
  int beats_by_action [8];
  logic [7:0] last_x = '0;
  logic [6:0] last_y = '0;

  always #1 clk = ~clk;

  mono_page_framebuffer_draw_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_action(in_action),
    .in_x_start(in_x_start), .in_y_start(in_y_start),
    .in_x_end(in_x_end), .in_y_end(in_y_end),
    .in_pixel_on(in_pixel_on), .in_low_bit_first(in_low_bit_first),
    .in_fill_value(in_fill_value), .in_read_column(in_read_column),
    .in_read_page(in_read_page),
    .out_valid(out_valid), .out_stall(out_stall), .out_read_data(out_read_data)
  );

  mfd_draw_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_action(in_action),
    .in_x_start(in_x_start), .in_y_start(in_y_start),
    .in_x_end(in_x_end), .in_y_end(in_y_end),
    .in_pixel_on(in_pixel_on), .in_low_bit_first(in_low_bit_first),
    .in_fill_value(in_fill_value), .in_read_column(in_read_column),
    .in_read_page(in_read_page),
    .out_valid(out_valid), .out_stall(out_stall), .out_read_data(out_read_data),
    .fail_count(fail_count), .outstanding(outstanding), .results_seen(results_seen)
  );

  // receiver: random stalls, or a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("** mono_page_framebuffer_draw_unit: FAILED **");
        $finish;
      end
    end
  end

  task automatic send_beat(input draw_beat_t b);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_action        <= b.action;
    in_x_start       <= b.x_start;
    in_y_start       <= b.y_start;
    in_x_end         <= b.x_end;
    in_y_end         <= b.y_end;
    in_pixel_on      <= b.pixel_on;
    in_low_bit_first <= b.low_bit_first;
    in_fill_value    <= b.fill_value;
    in_read_column   <= b.read_column;
    in_read_page     <= b.read_page;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_by_action[b.action]++;
  endtask

  task automatic directed(input logic [2:0] act, input logic [7:0] xs, input logic [6:0] ys,
                          input logic [7:0] xe, input logic [6:0] ye, input logic on,
                          input logic lsb, input logic [7:0] fill, input logic [6:0] col,
                          input logic [2:0] page);
    draw_beat_t b;
    b = '{act, xs, ys, xe, ye, on, lsb, fill, col, page};
    send_beat(b);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_x();
    if ($urandom_range(0, 99) < 85) return 8'($urandom_range(0, COLUMNS - 1));
    return 8'($urandom);
  endfunction

  function automatic logic [6:0] pick_y();
    if ($urandom_range(0, 99) < 85) return 7'($urandom_range(0, ROWS - 1));
    return 7'($urandom);
  endfunction

  function automatic int near(input int base, input int span, input int top);
    int v;
    v = base + $urandom_range(0, span);
    return (v > top) ? top : v;
  endfunction

  task automatic run_random(input int count);
    draw_beat_t b;
    logic [63:0] noise;
    logic [7:0] xa;
    logic [7:0] xb;
    logic [6:0] ya;
    logic [6:0] yb;
    int r;
    int shape;
    repeat (count) begin
      noise = {$urandom, $urandom};
      b = noise[$bits(draw_beat_t)-1:0];
      r = $urandom_range(0, 99);
      shape = $urandom_range(0, 99);
      xa = pick_x();
      ya = pick_y();
      xb = 8'(near(xa, 12, 255));
      yb = 7'(near(ya, 10, 127));
      if (r < 34) begin
        b.action = ACT_PLOT;
        b.x_start = xa;
        b.y_start = ya;
      end else if (r < 58) begin
        b.action = (r < 46) ? ACT_RECT : ACT_FILL;
        if (b.action == ACT_FILL) begin
          xb = 8'(near(xa, 8, 255));
          yb = 7'(near(ya, 8, 127));
        end
        // rect outlines keep the noise corners now and then: full 8-bit walks
        if (!(b.action == ACT_RECT && shape < 5)) begin
          b.x_start = xa;
          b.x_end   = xb;
          b.y_start = ya;
          b.y_end   = yb;
          if (shape >= 5 && shape < 13) begin
            b.x_start = xb;
            b.x_end   = xa;
          end else if (shape >= 13 && shape < 20) begin
            b.y_start = yb;
            b.y_end   = ya;
          end else if (b.action == ACT_FILL && shape == 99) begin
            b.x_start = '0;
            b.x_end   = 8'(COLUMNS);
            b.y_start = '0;
            b.y_end   = 7'(ROWS);
          end
        end
      end else if (r < 60) begin
        b.action = ACT_FILL_ALL;
      end else if (r < 94) begin
        b.action = ACT_READ;
        if (shape < 60) begin
          b.read_column = last_x[6:0] + 7'($urandom_range(0, 3));
          b.read_page   = last_y[5:3];
        end
      end else begin
        b.action = ACT_SPARE_FIRST + 3'($urandom_range(0, 2));
      end
      send_beat(b);
      if (b.action == ACT_PLOT || b.action == ACT_RECT || b.action == ACT_FILL) begin
        if (b.x_start > COLUMNS - 1 || b.y_start > ROWS - 1) begin
          last_x = '0;
          last_y = '0;
        end else begin
          last_x = b.x_start;
          last_y = b.y_start;
        end
      end
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    directed(ACT_READ,     0,   0,   0,   0,   0, 0, 8'h00,   0, 0);
    directed(ACT_PLOT,     0,   0,   0,   0,   1, 0, 8'h00,   0, 0);
    directed(ACT_PLOT,   127,  63,   0,   0,   1, 1, 8'h00,   0, 0);
    directed(ACT_PLOT,   255, 127, 255, 127,   1, 1, 8'hff, 127, 7);
    directed(ACT_PLOT,   128,   5,   0,   0,   1, 0, 8'h00,   0, 0);
    directed(ACT_READ,     0,   0,   0,   0,   0, 0, 8'h00,   0, 0);
    directed(ACT_READ,     0,   0,   0,   0,   0, 0, 8'h00, 127, 7);
    directed(ACT_RECT,     0,   0, 255, 127,   1, 0, 8'h00,   0, 0);
    directed(ACT_READ,     0,   0,   0,   0,   0, 0, 8'h00,   5, 0);
    directed(ACT_RECT,    10,   5,   3,  20,   1, 1, 8'h00,   0, 0);
    directed(ACT_RECT,     3,  20,  10,   5,   0, 1, 8'h00,   0, 0);
    directed(ACT_READ,     0,   0,   0,   0,   0, 0, 8'h00,   3, 2);
    directed(ACT_FILL,     0,   0, 128,  64,   0, 1, 8'h00,   0, 0);
    directed(ACT_READ,     0,   0,   0,   0,   0, 0, 8'h00, 127, 7);
    directed(ACT_FILL,    40,  10,  40,  30,   1, 0, 8'h00,   0, 0);
    directed(ACT_FILL,   125,  60, 130,  66,   1, 0, 8'h00,   0, 0);
    directed(ACT_READ,     0,   0,   0,   0,   0, 0, 8'h00,   0, 0);
    directed(ACT_FILL_ALL, 0,   0,   0,   0,   0, 0, 8'hff,   0, 0);
    directed(ACT_PLOT,    64,  24,   0,   0,   0, 0, 8'h00,   0, 0);
    directed(ACT_READ,     0,   0,   0,   0,   0, 0, 8'h00,  64, 3);
    directed(ACT_FILL_ALL, 0,   0,   0,   0,   0, 0, 8'h5a,   0, 0);
    directed(ACT_SPARE_FIRST + 3'd2, 255, 127, 255, 127, 1, 1, 8'hff, 127, 7);
    directed(ACT_SPARE_FIRST, 0, 0, 0, 0, 0, 0, 8'h00, 0, 0);
    directed(ACT_READ,   255, 127, 255, 127,   1, 1, 8'hff,  64, 3);
    directed(ACT_RECT,     7,   7,   7,   7,   1, 0, 8'h00,   0, 0);
    directed(ACT_READ,     0,   0,   0,   0,   0, 0, 8'h00,   7, 0);

    run_random(600);
    wait_drained();

    tx_idle_pct = 84;
    rx_idle_pct <= 20;
    run_random(600);
    wait_drained();

    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    hold_req <= hold_req + 1;
    run_random(40);
    run_random(600);
    wait_drained();

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d plot, %0d rectangle, %0d fill area, %0d fill all, %0d read beats",
             beats_by_action[ACT_PLOT], beats_by_action[ACT_RECT], beats_by_action[ACT_FILL],
             beats_by_action[ACT_FILL_ALL], beats_by_action[ACT_READ]);
    $display("plus %0d unused-code beats; %0d result beats compared across three stall mixes",
             beats_by_action[ACT_SPARE_FIRST] + beats_by_action[ACT_SPARE_FIRST + 3'd1]
             + beats_by_action[ACT_SPARE_FIRST + 3'd2], results_seen);
    if (fail_count == 0 && outstanding == 0) begin
      $display("** mono_page_framebuffer_draw_unit: PASSED **");
    end else begin
      $display("** mono_page_framebuffer_draw_unit: FAILED **");
    end
    $finish;
  end

endmodule
